@@ hw/rtl/ihc_pkg.sv @@
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types and constants for the IPv4 header checker: verdict and
// protocol codes, register indexes and the per-packet summary record.
// ----------------------------------------------------------------------------
package ihc_pkg;

	// byte-level constants
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned COUNT_W       = 16;
	localparam int unsigned SUM_W         = 17;
	localparam int unsigned HDR_BYTES_W   = 6;
	localparam int unsigned ADDR_W        = 32;
	localparam int unsigned LEN_W         = 16;
	localparam int unsigned CFG_DATA_W    = 32;
	localparam int unsigned CFG_IDX_W     = 1;

	localparam logic [COUNT_W-1:0] MIN_HEADER   = 16'd20;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;
	localparam logic [3:0]         IP_VERSION   = 4'h4;
	localparam logic [15:0]        FLAG_MF      = 16'h2000;
	localparam logic [15:0]        FRAG_OFFSET  = 16'h1FFF;
	localparam logic [LEN_W-1:0]   MAX_SIZE_RST = 16'd1500;

	// header byte positions
	localparam logic [COUNT_W-1:0] POS_VER_IHL  = 16'd0;
	localparam logic [COUNT_W-1:0] POS_TLEN_HI  = 16'd2;
	localparam logic [COUNT_W-1:0] POS_TLEN_LO  = 16'd3;
	localparam logic [COUNT_W-1:0] POS_FLAGS_HI = 16'd6;
	localparam logic [COUNT_W-1:0] POS_FLAGS_LO = 16'd7;
	localparam logic [COUNT_W-1:0] POS_PROTO    = 16'd9;
	localparam logic [COUNT_W-1:0] POS_CSUM_HI  = 16'd10;
	localparam logic [COUNT_W-1:0] POS_CSUM_LO  = 16'd11;
	localparam logic [COUNT_W-1:0] POS_SRC      = 16'd12;
	localparam logic [COUNT_W-1:0] POS_DST      = 16'd16;
	localparam logic [COUNT_W-1:0] POS_HDR_END  = 16'd20;

	// protocol numbers
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	// queue depth between front and back
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE = 1'b1;

	typedef enum logic [3:0] {
		VERDICT_OK       = 4'd0,
		VERDICT_SHORT    = 4'd1,
		VERDICT_LONG     = 4'd2,
		VERDICT_VERSION  = 4'd3,
		VERDICT_HDRLEN   = 4'd4,
		VERDICT_FRAGMENT = 4'd5,
		VERDICT_ZEROLEN  = 4'd6,
		VERDICT_DEST     = 4'd7,
		VERDICT_CHECKSUM = 4'd8,
		VERDICT_PROTOCOL = 4'd9
	} verdict_t;

	typedef enum logic [1:0] {
		PCLASS_ICMP  = 2'd0,
		PCLASS_TCP   = 2'd1,
		PCLASS_UDP   = 2'd2,
		PCLASS_OTHER = 2'd3
	} pclass_t;

	// summary of one packet, handed from front to back
	typedef struct packed {
		logic [COUNT_W-1:0]     byte_count;
		logic [3:0]             version;
		logic [HDR_BYTES_W-1:0] hdr_bytes;
		logic                   fragment;
		logic [LEN_W-1:0]       total_length;
		logic [SUM_W-1:0]       sum;
		logic [15:0]            stored_checksum;
		pclass_t                pclass;
		logic [ADDR_W-1:0]      source;
		logic [ADDR_W-1:0]      dest;
	} pkt_rec_t;

	// protocol byte to class
	function automatic pclass_t classify_proto(input logic [7:0] proto);
		pclass_t c;
		unique case (proto)
			PROTO_ICMP: c = PCLASS_ICMP;
			PROTO_TCP:  c = PCLASS_TCP;
			PROTO_UDP:  c = PCLASS_UDP;
			default:    c = PCLASS_OTHER;
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/ihc_front.sv @@
// ----------------------------------------------------------------------------
// ihc_front
// Byte parser: counts bytes, captures header fields and keeps the running
// ones'-complement header sum; on the last byte it emits a packet summary.
// ----------------------------------------------------------------------------
module ihc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    data_byte,
	input  logic                          last_byte,
	input  logic                          queue_full,
	output logic                          push,
	output ihc_pkg::pkt_rec_t             push_rec
);
	import ihc_pkg::*;

	logic [COUNT_W-1:0] byte_count_q, byte_count_n;
	logic [SUM_W-1:0]   sum_q, sum_n;
	logic [7:0]         hold_q, hold_n;
	logic [7:0]         ver_ihl_q, ver_ihl_n;
	logic [15:0]        flags_q, flags_n;
	logic [LEN_W-1:0]   tlen_q, tlen_n;
	logic [15:0]        csum_q, csum_n;
	logic [7:0]         proto_q, proto_n;
	logic [ADDR_W-1:0]  src_q, src_n;
	logic [ADDR_W-1:0]  dst_q, dst_n;
	logic [HDR_BYTES_W-1:0] hb_n;
	logic [15:0]        word;
	logic [SUM_W:0]     sum_wide;
	logic               accept;
	logic [COUNT_W-1:0] pos;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign pos      = byte_count_q;

	// field capture by byte position
	always_comb begin
		ver_ihl_n = ver_ihl_q;
		tlen_n    = tlen_q;
		flags_n   = flags_q;
		proto_n   = proto_q;
		csum_n    = csum_q;
		src_n     = src_q;
		dst_n     = dst_q;
		if (pos == POS_VER_IHL) begin
			ver_ihl_n = data_byte;
		end else if (pos == POS_TLEN_HI || pos == POS_TLEN_LO) begin
			tlen_n = {tlen_q[7:0], data_byte};
		end else if (pos == POS_FLAGS_HI || pos == POS_FLAGS_LO) begin
			flags_n = {flags_q[7:0], data_byte};
		end else if (pos == POS_PROTO) begin
			proto_n = data_byte;
		end else if (pos == POS_CSUM_HI || pos == POS_CSUM_LO) begin
			csum_n = {csum_q[7:0], data_byte};
		end else if (pos >= POS_SRC && pos < POS_DST) begin
			src_n = {src_q[23:0], data_byte};
		end else if (pos >= POS_DST && pos < POS_HDR_END) begin
			dst_n = {dst_q[23:0], data_byte};
		end
	end

	assign hb_n = {ver_ihl_n[3:0], 2'b00};

	// running header sum, checksum word counted as zero
	always_comb begin
		hold_n   = hold_q;
		sum_n    = sum_q;
		word     = (pos == POS_CSUM_LO) ? 16'h0000 : {hold_q, data_byte};
		sum_wide = {1'b0, sum_q} + {2'b00, word};
		if (!pos[0]) begin
			hold_n = data_byte;
		end else if (pos < {{(COUNT_W-HDR_BYTES_W){1'b0}}, hb_n}) begin
			sum_n = {1'b0, sum_wide[15:0]} + {{(SUM_W-2){1'b0}}, sum_wide[SUM_W:16]};
		end
	end

	// saturating byte counter
	assign byte_count_n = (byte_count_q != COUNT_MAX) ? byte_count_q + 1'b1 : byte_count_q;

	// summary of the packet as it stands after this byte
	always_comb begin
		push                     = accept && last_byte;
		push_rec.byte_count      = byte_count_n;
		push_rec.version         = ver_ihl_n[7:4];
		push_rec.hdr_bytes       = hb_n;
		push_rec.fragment        = ((flags_n & FLAG_MF) != 16'h0000) ||
		                           ((flags_n & FRAG_OFFSET) != 16'h0000);
		push_rec.total_length    = tlen_n;
		push_rec.sum             = sum_n;
		push_rec.stored_checksum = csum_n;
		push_rec.pclass          = classify_proto(proto_n);
		push_rec.source          = src_n;
		push_rec.dest            = dst_n;
	end

	// per-packet state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			sum_q        <= '0;
			hold_q       <= '0;
			ver_ihl_q    <= '0;
			flags_q      <= '0;
			tlen_q       <= '0;
			csum_q       <= '0;
			proto_q      <= '0;
			src_q        <= '0;
			dst_q        <= '0;
		end else if (accept) begin
			if (last_byte) begin
				byte_count_q <= '0;
				sum_q        <= '0;
				hold_q       <= '0;
				ver_ihl_q    <= '0;
				flags_q      <= '0;
				tlen_q       <= '0;
				csum_q       <= '0;
				proto_q      <= '0;
				src_q        <= '0;
				dst_q        <= '0;
			end else begin
				byte_count_q <= byte_count_n;
				sum_q        <= sum_n;
				hold_q       <= hold_n;
				ver_ihl_q    <= ver_ihl_n;
				flags_q      <= flags_n;
				tlen_q       <= tlen_n;
				csum_q       <= csum_n;
				proto_q      <= proto_n;
				src_q        <= src_n;
				dst_q        <= dst_n;
			end
		end
	end

	// a finished packet leaves the counter at zero
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (byte_count_q == '0 && sum_q == '0))
		else $error("byte count not cleared after last byte");

	// count and sum hold while no byte is taken
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(byte_count_q) && $stable(sum_q))
		else $error("front state moved without an accepted byte");

endmodule

@@ hw/rtl/ihc_queue.sv @@
// ----------------------------------------------------------------------------
// ihc_queue
// Short queue of packet summaries between the parser and the verdict stage.
// ----------------------------------------------------------------------------
module ihc_queue #(
	parameter int unsigned DEPTH = ihc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  ihc_pkg::pkt_rec_t wr_rec,
	input  logic              rd_en,
	output ihc_pkg::pkt_rec_t rd_rec,
	output logic              empty,
	output logic              full
);
	import ihc_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	pkt_rec_t           mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign empty  = (count_q == '0);
	assign full   = (count_q == CNT_FULL);
	assign rd_rec = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("write into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty)
		else $error("read from an empty queue");

endmodule

@@ hw/rtl/ihc_back.sv @@
// ----------------------------------------------------------------------------
// ihc_back
// Verdict stage: holds the configuration registers, runs the ordered checks
// on a packet summary and keeps the result in an output register.
// ----------------------------------------------------------------------------
module ihc_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ihc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ihc_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  ihc_pkg::pkt_rec_t                    head_rec,
	input  logic                                 queue_empty,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [3:0]                           verdict,
	output logic [1:0]                           protocol_class,
	output logic [ihc_pkg::HDR_BYTES_W-1:0]      header_bytes,
	output logic [ihc_pkg::LEN_W-1:0]            payload_length,
	output logic [ihc_pkg::ADDR_W-1:0]           source_ip
);
	import ihc_pkg::*;

	logic [ADDR_W-1:0]      local_ip_q;
	logic [LEN_W-1:0]       max_size_q;
	logic                   out_valid_q;
	verdict_t               verdict_q, verdict_c;
	pclass_t                pclass_q;
	logic [HDR_BYTES_W-1:0] hb_q;
	logic [LEN_W-1:0]       payload_q, payload_c;
	logic [ADDR_W-1:0]      source_q;
	logic [15:0]            computed;
	logic [LEN_W-1:0]       hb_wide;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
			max_size_q <= MAX_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOCAL_IP: local_ip_q <= cfg_data;
				REG_MAX_SIZE: max_size_q <= cfg_data[LEN_W-1:0];
				default:      local_ip_q <= local_ip_q;
			endcase
		end
	end

	// ordered checks, first failure wins
	always_comb begin
		computed = ~head_rec.sum[15:0];
		hb_wide  = {{(LEN_W-HDR_BYTES_W){1'b0}}, head_rec.hdr_bytes};
		payload_c = (head_rec.total_length > hb_wide) ?
		            head_rec.total_length - hb_wide : '0;
		if (head_rec.byte_count < MIN_HEADER) begin
			verdict_c = VERDICT_SHORT;
		end else if (head_rec.byte_count > max_size_q) begin
			verdict_c = VERDICT_LONG;
		end else if (head_rec.version != IP_VERSION) begin
			verdict_c = VERDICT_VERSION;
		end else if (hb_wide < MIN_HEADER) begin
			verdict_c = VERDICT_HDRLEN;
		end else if (head_rec.fragment) begin
			verdict_c = VERDICT_FRAGMENT;
		end else if (head_rec.total_length == '0) begin
			verdict_c = VERDICT_ZEROLEN;
		end else if (head_rec.dest != local_ip_q) begin
			verdict_c = VERDICT_DEST;
		end else if (computed != head_rec.stored_checksum) begin
			verdict_c = VERDICT_CHECKSUM;
		end else if (head_rec.pclass == PCLASS_OTHER) begin
			verdict_c = VERDICT_PROTOCOL;
		end else begin
			verdict_c = VERDICT_OK;
		end
	end

	// take a summary whenever the output register is free or being drained
	assign pop = !queue_empty && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q <= verdict_c;
			pclass_q  <= head_rec.pclass;
			hb_q      <= head_rec.hdr_bytes;
			payload_q <= payload_c;
			source_q  <= head_rec.source;
		end
	end

	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign protocol_class = pclass_q;
	assign header_bytes   = hb_q;
	assign payload_length = payload_q;
	assign source_ip      = source_q;

	a_ok_has_known_proto: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict_q == VERDICT_OK) |-> (pclass_q != PCLASS_OTHER))
		else $error("ok verdict with an unknown protocol");

	a_ok_full_header: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict_q == VERDICT_OK) |-> (hb_q >= HDR_BYTES_W'(20)))
		else $error("ok verdict with a short header");

endmodule

@@ hw/rtl/ipv4_header_checker_unit.sv @@
// ----------------------------------------------------------------------------
// ipv4_header_checker_unit
// Checks received IPv4 packets byte by byte and reports one verdict each.
//
// Input channel: in_valid/in_ready carry data_byte and last_byte, one packet
// byte per item in wire order. One byte is taken every clock; in_ready only
// drops while the summary queue is full, that is once two finished packets
// wait behind a verdict that the receiver has not yet taken.
// Output channel: out_valid/out_ready carry verdict, protocol_class,
// header_bytes, payload_length and source_ip, one item per packet. The
// summary is written into the queue at the edge that accepts the last byte
// and moves into the verdict register, where out_valid rises, once that
// register is free or being drained.
// Throughput: one byte per clock while the summary queue is not full;
// verdicts leave at up to one per clock.
// Receiver stall: the verdict register holds, finished packets wait in the
// queue, and the parser keeps taking bytes until the queue fills.
// Configuration: cfg_we/cfg_index/cfg_data write local_ip (index 0) and
// max_packet_size (index 1); unenforced: the user writes while block is idle.
// Reset: all per-packet state clears, local_ip resets to 0 and
// max_packet_size to 1500; the block is ready in the first cycle after it.
// ----------------------------------------------------------------------------
module ipv4_header_checker_unit #(
	parameter int unsigned QUEUE_DEPTH = ihc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	input  logic                              last_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [3:0]                        verdict,
	output logic [1:0]                        protocol_class,
	output logic [ihc_pkg::HDR_BYTES_W-1:0]   header_bytes,
	output logic [ihc_pkg::LEN_W-1:0]         payload_length,
	output logic [ihc_pkg::ADDR_W-1:0]        source_ip,
	input  logic                              cfg_we,
	input  logic [ihc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ihc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ihc_pkg::*;

	logic     push, pop, q_empty, q_full;
	pkt_rec_t push_rec, head_rec;

	// byte parser
	ihc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.queue_full (q_full),
		.push       (push),
		.push_rec   (push_rec)
	);

	// summary queue
	ihc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_rec (push_rec),
		.rd_en  (pop),
		.rd_rec (head_rec),
		.empty  (q_empty),
		.full   (q_full)
	);

	// verdict stage
	ihc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.head_rec       (head_rec),
		.queue_empty    (q_empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.verdict        (verdict),
		.protocol_class (protocol_class),
		.header_bytes   (header_bytes),
		.payload_length (payload_length),
		.source_ip      (source_ip)
	);

endmodule
